[design/exptok_pkg.sv]
`default_nettype none
package exptok_pkg;

	// Scanner state between input transactions.
	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_INT,
		MODE_FRAC,
		MODE_IDENT
	} mode_t;

	typedef enum logic [3:0] {
		KIND_NUM     = 4'd0,
		KIND_IDENT   = 4'd1,
		KIND_PLUS    = 4'd2,
		KIND_MINUS   = 4'd3,
		KIND_MUL     = 4'd4,
		KIND_DIV     = 4'd5,
		KIND_OPEN    = 4'd6,
		KIND_CLOSE   = 4'd7,
		KIND_BANG    = 4'd8,
		KIND_PERCENT = 4'd9,
		KIND_COMMA   = 4'd10,
		KIND_END     = 4'd11
	} kind_t;

	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_EOS  = 1'b1;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_OPEN    = 8'h28;
	localparam logic [7:0] CH_CLOSE   = 8'h29;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_POINT   = 8'h2E;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	localparam int MANT_W = 63;
	localparam int NAME_W = 128;

	localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};
	// Largest mantissa that still takes one more digit: (MANT_MAX - d) / 10.
	localparam logic [MANT_W-1:0] MANT_LIMIT_LO = 63'd922337203685477580;
	localparam logic [MANT_W-1:0] MANT_LIMIT_HI = 63'd922337203685477579;

	localparam logic [7:0] FRAC_MAX = 8'd255;

	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		kind_t              kind;
		logic [MANT_W-1:0]  mantissa;
		logic [7:0]         frac_digits;
		logic [NAME_W-1:0]  name;
		logic [4:0]         name_len;
		logic               clipped;
		logic               last;
	} tok_t;

endpackage
`default_nettype wire

[design/exptok_core.sv]
`default_nettype none
module exptok_core #(
	parameter int MAX_NAME_CHARS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              cmd,
	input  wire logic [7:0]        ch,
	output logic [1:0]             push_n,
	output exptok_pkg::tok_t       res0,
	output exptok_pkg::tok_t       res1
);

	exptok_pkg::mode_t mode_q, mode_nx;
	logic [exptok_pkg::MANT_W-1:0] accum_q, accum_nx;
	logic [7:0] frac_q, frac_nx;
	logic [exptok_pkg::NAME_W-1:0] name_q, name_nx;
	logic [4:0] name_cnt_q, name_cnt_nx;
	logic clip_q, clip_nx;

	logic is_digit, is_alpha, is_name;
	logic [3:0] digit;
	logic fits;
	logic [exptok_pkg::MANT_W-1:0] accum_step;
	logic punct_hit;
	exptok_pkg::kind_t punct_kind;
	logic pending, do_flush, has_second;
	exptok_pkg::tok_t flush_tok, second_tok;

	always_comb begin
		is_digit = (ch >= exptok_pkg::CH_ZERO) && (ch <= exptok_pkg::CH_NINE);
		is_alpha = ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
		is_name  = is_digit || is_alpha || (ch == exptok_pkg::CH_UNDER);
		digit    = ch[3:0];
		fits     = accum_q <= ((digit > 4'd7) ? exptok_pkg::MANT_LIMIT_HI
			: exptok_pkg::MANT_LIMIT_LO);
		// Times ten as two shifted copies; fits guarantees no carry out.
		accum_step = (accum_q << 3) + (accum_q << 1)
			+ {{(exptok_pkg::MANT_W-4){1'b0}}, digit};
	end

	always_comb begin
		punct_hit  = 1'b1;
		punct_kind = exptok_pkg::KIND_PLUS;
		unique case (ch)
			exptok_pkg::CH_PLUS:    punct_kind = exptok_pkg::KIND_PLUS;
			exptok_pkg::CH_MINUS:   punct_kind = exptok_pkg::KIND_MINUS;
			exptok_pkg::CH_STAR:    punct_kind = exptok_pkg::KIND_MUL;
			exptok_pkg::CH_SLASH:   punct_kind = exptok_pkg::KIND_DIV;
			exptok_pkg::CH_OPEN:    punct_kind = exptok_pkg::KIND_OPEN;
			exptok_pkg::CH_CLOSE:   punct_kind = exptok_pkg::KIND_CLOSE;
			exptok_pkg::CH_BANG:    punct_kind = exptok_pkg::KIND_BANG;
			exptok_pkg::CH_PERCENT: punct_kind = exptok_pkg::KIND_PERCENT;
			exptok_pkg::CH_COMMA:   punct_kind = exptok_pkg::KIND_COMMA;
			default:                punct_hit = 1'b0;
		endcase
	end

	always_comb begin
		pending = mode_q != exptok_pkg::MODE_IDLE;

		flush_tok = '0;
		flush_tok.clipped = clip_q;
		if (mode_q == exptok_pkg::MODE_IDENT) begin
			flush_tok.kind     = exptok_pkg::KIND_IDENT;
			flush_tok.name     = name_q;
			flush_tok.name_len = name_cnt_q;
		end else begin
			flush_tok.kind        = exptok_pkg::KIND_NUM;
			flush_tok.mantissa    = accum_q;
			flush_tok.frac_digits = frac_q;
		end

		second_tok = '0;
		second_tok.kind = (cmd == exptok_pkg::CMD_EOS) ? exptok_pkg::KIND_END : punct_kind;

		mode_nx     = mode_q;
		accum_nx    = accum_q;
		frac_nx     = frac_q;
		name_nx     = name_q;
		name_cnt_nx = name_cnt_q;
		clip_nx     = clip_q;
		do_flush    = 1'b0;
		has_second  = 1'b0;

		if (cmd == exptok_pkg::CMD_EOS) begin
			do_flush   = pending;
			has_second = 1'b1;
			mode_nx    = exptok_pkg::MODE_IDLE;
			accum_nx   = '0;
			frac_nx    = '0;
			name_nx    = '0;
			name_cnt_nx = '0;
			clip_nx    = 1'b0;
		end else if ((mode_q == exptok_pkg::MODE_INT || mode_q == exptok_pkg::MODE_FRAC)
				&& is_digit) begin
			if (mode_q == exptok_pkg::MODE_INT) begin
				if (fits) begin
					accum_nx = accum_step;
				end else begin
					accum_nx = exptok_pkg::MANT_MAX;
					clip_nx  = 1'b1;
				end
			end else if (fits && (frac_q != exptok_pkg::FRAC_MAX)) begin
				accum_nx = accum_step;
				frac_nx  = frac_q + 8'd1;
			end else begin
				clip_nx = 1'b1;
			end
		end else if (mode_q == exptok_pkg::MODE_INT && ch == exptok_pkg::CH_POINT) begin
			mode_nx = exptok_pkg::MODE_FRAC;
		end else if (mode_q == exptok_pkg::MODE_IDENT && is_name) begin
			if (name_cnt_q < 5'(MAX_NAME_CHARS)) begin
				for (int i = 0; i < 16; i++) begin
					if (name_cnt_q[3:0] == 4'(i)) name_nx[i*8 +: 8] = ch;
				end
				name_cnt_nx = name_cnt_q + 5'd1;
			end else begin
				clip_nx = 1'b1;
			end
		end else begin
			// The character closes any pending token and starts afresh.
			do_flush    = pending;
			mode_nx     = exptok_pkg::MODE_IDLE;
			accum_nx    = '0;
			frac_nx     = '0;
			name_nx     = '0;
			name_cnt_nx = '0;
			clip_nx     = 1'b0;
			if (is_digit) begin
				mode_nx  = exptok_pkg::MODE_INT;
				accum_nx = {{(exptok_pkg::MANT_W-4){1'b0}}, digit};
			end else if (is_name) begin
				mode_nx      = exptok_pkg::MODE_IDENT;
				name_nx[7:0] = ch;
				name_cnt_nx  = 5'd1;
			end else begin
				has_second = punct_hit;
			end
		end

		push_n = {1'b0, do_flush} + {1'b0, has_second};
		res0 = do_flush ? flush_tok : second_tok;
		res1 = second_tok;
		res0.last = !(do_flush && has_second);
		res1.last = 1'b1;
		if (!advance) push_n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= exptok_pkg::MODE_IDLE;
			accum_q    <= '0;
			frac_q     <= '0;
			name_q     <= '0;
			name_cnt_q <= '0;
			clip_q     <= 1'b0;
		end else if (advance) begin
			mode_q     <= mode_nx;
			accum_q    <= accum_nx;
			frac_q     <= frac_nx;
			name_q     <= name_nx;
			name_cnt_q <= name_cnt_nx;
			clip_q     <= clip_nx;
		end
	end

	a_ident_state: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == exptok_pkg::MODE_IDENT |-> accum_q == '0 && name_cnt_q != 5'd0
			&& name_cnt_q <= 5'(MAX_NAME_CHARS))
		else $error("identifier state holds number data or a bad length");

	a_num_state: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == exptok_pkg::MODE_INT || mode_q == exptok_pkg::MODE_FRAC)
			|-> name_cnt_q == 5'd0 && name_q == '0)
		else $error("number state holds identifier data");

endmodule
`default_nettype wire

[design/exptok_fifo.sv]
`default_nettype none
module exptok_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        push_n,
	input  wire exptok_pkg::tok_t  wr0,
	input  wire exptok_pkg::tok_t  wr1,
	input  wire logic              pop,
	output logic                   valid,
	output logic                   room,
	output exptok_pkg::tok_t       head
);

	localparam int AW = $clog2(exptok_pkg::FIFO_DEPTH);
	localparam int CW = $clog2(exptok_pkg::FIFO_DEPTH + 1);

	exptok_pkg::tok_t mem_q [exptok_pkg::FIFO_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [CW-1:0] count_q;
	logic do_pop;

	assign valid   = count_q != '0;
	assign room    = count_q <= CW'(exptok_pkg::FIFO_DEPTH - 2);
	assign head    = mem_q[rd_ptr_q];
	assign do_pop  = pop && valid;
	assign wr_ptr1 = wr_ptr_q + AW'(1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_ptr_q] <= wr0;
		if (push_n == 2'd2) mem_q[wr_ptr1] <= wr1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push_n);
			rd_ptr_q <= rd_ptr_q + AW'(do_pop);
			count_q  <= count_q + CW'(push_n) - CW'(do_pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(exptok_pkg::FIFO_DEPTH))
		else $error("result queue count out of range");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> room)
		else $error("results pushed without room for two");

endmodule
`default_nettype wire

[design/expression_tokenizer.sv]
// Streaming tokenizer for arithmetic expressions.
// Input channel (in_valid/in_ready): one transaction per character (cmd = 0,
// code on ch) or an end-of-string marker (cmd = 1). Output channel
// (out_valid/out_ready): one token per transaction with kind, the number
// fields (mantissa, frac_digits), the identifier fields (name_low, name_high,
// name_len), clipped, and last marking the final token caused by an input.
// A character yields zero, one or two tokens; end of string yields the
// pending token, if any, followed by the end token.
// An accepted input is registered, decoded from that register into the result
// queue, and its first token is offered from the queue head.
// Throughput: one character per cycle while each yields at most one token
// and out_ready stays high; the output port drains one token per cycle, so
// characters that close a token and emit a punctuation token can hold back input.
// The rate is set by the single decode and shift-add stage in front of a
// four-entry result queue; decode advances only while the queue has room
// for two tokens.
// When the receiver stalls, up to four tokens queue up, then in_ready drops
// after one more input is held. Reset clears the scanner to between tokens
// and empties the queue.
`default_nettype none
module expression_tokenizer #(
	parameter int MAX_NAME_CHARS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [7:0]  ch,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       kind,
	output logic [62:0]      mantissa,
	output logic [7:0]       frac_digits,
	output logic [63:0]      name_low,
	output logic [63:0]      name_high,
	output logic [4:0]       name_len,
	output logic             clipped,
	output logic             last
);

	logic valid_s1;
	logic cmd_s1;
	logic [7:0] ch_s1;
	logic advance, room;
	logic [1:0] push_n;
	exptok_pkg::tok_t res0, res1, head;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= cmd;
			ch_s1  <= ch;
		end
	end

	exptok_core #(
		.MAX_NAME_CHARS(MAX_NAME_CHARS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cmd     (cmd_s1),
		.ch      (ch_s1),
		.push_n  (push_n),
		.res0    (res0),
		.res1    (res1)
	);

	exptok_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.wr0    (res0),
		.wr1    (res1),
		.pop    (out_ready),
		.valid  (out_valid),
		.room   (room),
		.head   (head)
	);

	assign kind        = head.kind;
	assign mantissa    = head.mantissa;
	assign frac_digits = head.frac_digits;
	assign name_low    = head.name[63:0];
	assign name_high   = head.name[127:64];
	assign name_len    = head.name_len;
	assign clipped     = head.clipped;
	assign last        = head.last;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(ch_s1) && $stable(cmd_s1))
		else $error("held input transaction was lost or changed");

endmodule
`default_nettype wire

[dv/tb_expression_tokenizer.sv]
`timescale 1ns / 1ps
module tb_expression_tokenizer;

	localparam int NAME_CAP       = 16;
	localparam int RANDOM_ITEMS   = 650;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 10;

	typedef struct packed {
		exptok_pkg::kind_t kind;
		logic [62:0]  mant;
		logic [7:0]   frac;
		logic [63:0]  lo;
		logic [63:0]  hi;
		logic [4:0]   len;
		logic         clip;
		logic         last;
	} token_t;

	// When typed is set, the row's transaction yields exactly one token of the
	// given kind with last set and every other field zero.
	typedef struct packed {
		logic   cmd;
		logic [7:0] ch;
		logic   typed;
		exptok_pkg::kind_t kind;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd = exptok_pkg::CMD_CHAR;
	logic [7:0]  ch = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  kind;
	logic [62:0] mantissa;
	logic [7:0]  frac_digits;
	logic [63:0] name_low;
	logic [63:0] name_high;
	logic [4:0]  name_len;
	logic        clipped;
	logic        last;

	row_t   char_stream[$];
	token_t batch[$];
	token_t awaited_tokens[$];
	int     taken = 0;
	int     errors = 0;
	int     quiet_cycles = 0;
	int     ready_style = 0;
	int     ready_left = 0;

	// Scanner state of the predictor.
	exptok_pkg::mode_t cur_mode = exptok_pkg::MODE_IDLE;
	logic [62:0]  accum = '0;
	logic [7:0]   frac_cnt = '0;
	logic [127:0] name_buf = '0;
	logic [4:0]   name_cnt = '0;
	logic         lost_info = 1'b0;

	row_t directed_rows [0:23] = '{
		'{exptok_pkg::CMD_CHAR, exptok_pkg::CH_PLUS,    1'b1, exptok_pkg::KIND_PLUS},
		'{exptok_pkg::CMD_CHAR, exptok_pkg::CH_MINUS,   1'b1, exptok_pkg::KIND_MINUS},
		'{exptok_pkg::CMD_CHAR, exptok_pkg::CH_STAR,    1'b1, exptok_pkg::KIND_MUL},
		'{exptok_pkg::CMD_CHAR, exptok_pkg::CH_SLASH,   1'b1, exptok_pkg::KIND_DIV},
		'{exptok_pkg::CMD_CHAR, exptok_pkg::CH_OPEN,    1'b1, exptok_pkg::KIND_OPEN},
		'{exptok_pkg::CMD_CHAR, exptok_pkg::CH_CLOSE,   1'b1, exptok_pkg::KIND_CLOSE},
		'{exptok_pkg::CMD_CHAR, exptok_pkg::CH_BANG,    1'b1, exptok_pkg::KIND_BANG},
		'{exptok_pkg::CMD_CHAR, exptok_pkg::CH_PERCENT, 1'b1, exptok_pkg::KIND_PERCENT},
		'{exptok_pkg::CMD_CHAR, exptok_pkg::CH_COMMA,   1'b1, exptok_pkg::KIND_COMMA},
		'{exptok_pkg::CMD_EOS,  8'hFF,                  1'b1, exptok_pkg::KIND_END},
		'{exptok_pkg::CMD_CHAR, 8'h61,                  1'b0, exptok_pkg::KIND_NUM},
		'{exptok_pkg::CMD_CHAR, exptok_pkg::CH_UNDER,   1'b0, exptok_pkg::KIND_NUM},
		'{exptok_pkg::CMD_CHAR, 8'h31,                  1'b0, exptok_pkg::KIND_NUM},
		'{exptok_pkg::CMD_CHAR, 8'h20,                  1'b0, exptok_pkg::KIND_NUM},
		'{exptok_pkg::CMD_CHAR, 8'h31,                  1'b0, exptok_pkg::KIND_NUM},
		'{exptok_pkg::CMD_CHAR, exptok_pkg::CH_POINT,   1'b0, exptok_pkg::KIND_NUM},
		'{exptok_pkg::CMD_CHAR, 8'h35,                  1'b0, exptok_pkg::KIND_NUM},
		'{exptok_pkg::CMD_CHAR, exptok_pkg::CH_POINT,   1'b0, exptok_pkg::KIND_NUM},
		'{exptok_pkg::CMD_CHAR, 8'h5A,                  1'b0, exptok_pkg::KIND_NUM},
		'{exptok_pkg::CMD_CHAR, 8'hC8,                  1'b0, exptok_pkg::KIND_NUM},
		'{exptok_pkg::CMD_CHAR, 8'h00,                  1'b0, exptok_pkg::KIND_NUM},
		'{exptok_pkg::CMD_CHAR, 8'h37,                  1'b0, exptok_pkg::KIND_NUM},
		'{exptok_pkg::CMD_CHAR, exptok_pkg::CH_POINT,   1'b0, exptok_pkg::KIND_NUM},
		'{exptok_pkg::CMD_EOS,  8'h00,                  1'b0, exptok_pkg::KIND_NUM}
	};

	expression_tokenizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.ch         (ch),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.mantissa   (mantissa),
		.frac_digits(frac_digits),
		.name_low   (name_low),
		.name_high  (name_high),
		.name_len   (name_len),
		.clipped    (clipped),
		.last       (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit is_digit_ch(input logic [7:0] c);
		return c >= exptok_pkg::CH_ZERO && c <= exptok_pkg::CH_NINE;
	endfunction

	function automatic bit is_name_ch(input logic [7:0] c);
		return is_digit_ch(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			c == exptok_pkg::CH_UNDER;
	endfunction

	// KIND_END never comes from a character, so it marks "not punctuation".
	function automatic exptok_pkg::kind_t punct_of(input logic [7:0] c);
		case (c)
			exptok_pkg::CH_PLUS:    return exptok_pkg::KIND_PLUS;
			exptok_pkg::CH_MINUS:   return exptok_pkg::KIND_MINUS;
			exptok_pkg::CH_STAR:    return exptok_pkg::KIND_MUL;
			exptok_pkg::CH_SLASH:   return exptok_pkg::KIND_DIV;
			exptok_pkg::CH_OPEN:    return exptok_pkg::KIND_OPEN;
			exptok_pkg::CH_CLOSE:   return exptok_pkg::KIND_CLOSE;
			exptok_pkg::CH_BANG:    return exptok_pkg::KIND_BANG;
			exptok_pkg::CH_PERCENT: return exptok_pkg::KIND_PERCENT;
			exptok_pkg::CH_COMMA:   return exptok_pkg::KIND_COMMA;
			default:                return exptok_pkg::KIND_END;
		endcase
	endfunction

	function automatic token_t blank_token(input exptok_pkg::kind_t k);
		token_t t;
		t = '0;
		t.kind = k;
		return t;
	endfunction

	task automatic close_token();
		token_t t;
		t = '0;
		if (cur_mode == exptok_pkg::MODE_INT || cur_mode == exptok_pkg::MODE_FRAC) begin
			t.kind = exptok_pkg::KIND_NUM;
			t.mant = accum;
			t.frac = frac_cnt;
			t.clip = lost_info;
			batch.push_back(t);
		end else if (cur_mode == exptok_pkg::MODE_IDENT) begin
			t.kind = exptok_pkg::KIND_IDENT;
			t.lo = name_buf[63:0];
			t.hi = name_buf[127:64];
			t.len = name_cnt;
			t.clip = lost_info;
			batch.push_back(t);
		end
		cur_mode = exptok_pkg::MODE_IDLE;
		accum = '0;
		frac_cnt = '0;
		name_buf = '0;
		name_cnt = '0;
		lost_info = 1'b0;
	endtask

	task automatic take_name_char(input logic [7:0] c);
		if (name_cnt < NAME_CAP) begin
			name_buf[{name_cnt, 3'b000} +: 8] = c;
			name_cnt = name_cnt + 5'd1;
		end else begin
			lost_info = 1'b1;
		end
	endtask

	// A digit is taken only while the mantissa times ten plus the digit still fits.
	task automatic take_digit(input logic [7:0] c);
		logic [63:0] d;
		logic [63:0] room;
		logic [63:0] wide;
		d = 64'(c - exptok_pkg::CH_ZERO);
		room = (64'(exptok_pkg::MANT_MAX) - d) / 64'd10;
		wide = {1'b0, accum};
		if (cur_mode == exptok_pkg::MODE_INT) begin
			if (wide <= room) begin
				accum = 63'(wide * 64'd10 + d);
			end else begin
				accum = exptok_pkg::MANT_MAX;
				lost_info = 1'b1;
			end
		end else if (wide <= room && frac_cnt != exptok_pkg::FRAC_MAX) begin
			accum = 63'(wide * 64'd10 + d);
			frac_cnt = frac_cnt + 8'd1;
		end else begin
			lost_info = 1'b1;
		end
	endtask

	// Leaves in batch the tokens that one input transaction produces.
	task automatic predict_tokens(input logic c_cmd, input logic [7:0] c);
		token_t t;
		exptok_pkg::kind_t k;
		batch.delete();
		if (c_cmd == exptok_pkg::CMD_EOS) begin
			close_token();
			batch.push_back(blank_token(exptok_pkg::KIND_END));
		end else if ((cur_mode == exptok_pkg::MODE_INT || cur_mode == exptok_pkg::MODE_FRAC)
				&& is_digit_ch(c)) begin
			take_digit(c);
		end else if (cur_mode == exptok_pkg::MODE_INT && c == exptok_pkg::CH_POINT) begin
			cur_mode = exptok_pkg::MODE_FRAC;
		end else if (cur_mode == exptok_pkg::MODE_IDENT && is_name_ch(c)) begin
			take_name_char(c);
		end else begin
			close_token();
			k = punct_of(c);
			if (is_digit_ch(c)) begin
				cur_mode = exptok_pkg::MODE_INT;
				accum = 63'(c - exptok_pkg::CH_ZERO);
			end else if (is_name_ch(c)) begin
				cur_mode = exptok_pkg::MODE_IDENT;
				take_name_char(c);
			end else if (k != exptok_pkg::KIND_END) begin
				batch.push_back(blank_token(k));
			end
		end
		if (batch.size() != 0) begin
			t = batch.pop_back();
			t.last = 1'b1;
			batch.push_back(t);
		end
	endtask

	task automatic add_char(input logic [7:0] c);
		char_stream.push_back('{exptok_pkg::CMD_CHAR, c, 1'b0, exptok_pkg::KIND_NUM});
	endtask

	task automatic add_eos();
		char_stream.push_back('{exptok_pkg::CMD_EOS, 8'($urandom_range(0, 255)), 1'b0,
			exptok_pkg::KIND_NUM});
	endtask

	task automatic add_digits(input int n);
		for (int i = 0; i < n; i++)
			add_char(exptok_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic add_space();
		int w;
		w = $urandom_range(0, 5);
		add_char(w == 5 ? 8'h20 : 8'(9 + w));
	endtask

	task automatic add_name_start();
		int p;
		p = $urandom_range(0, 52);
		if (p == 52)
			add_char(exptok_pkg::CH_UNDER);
		else
			add_char(p < 26 ? 8'(8'h41 + p) : 8'(8'h61 + p - 26));
	endtask

	task automatic add_operator();
		logic [7:0] ops [0:8];
		ops = '{exptok_pkg::CH_PLUS, exptok_pkg::CH_MINUS, exptok_pkg::CH_STAR,
			exptok_pkg::CH_SLASH, exptok_pkg::CH_OPEN, exptok_pkg::CH_CLOSE,
			exptok_pkg::CH_BANG, exptok_pkg::CH_PERCENT, exptok_pkg::CH_COMMA};
		add_char(ops[$urandom_range(0, 8)]);
	endtask

	// Mostly well-formed expressions; noise characters and stray points mixed in.
	task automatic build_random_stream();
		string near_max;
		int    target;
		int    pick;
		int    n;
		near_max = "922337203685477580";
		target = char_stream.size() + RANDOM_ITEMS;
		// Enough zero fraction digits to run the fraction count past its limit.
		add_char(exptok_pkg::CH_ZERO);
		add_char(exptok_pkg::CH_POINT);
		for (int i = 0; i < 256; i++)
			add_char(exptok_pkg::CH_ZERO);
		add_eos();
		while (char_stream.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				add_digits(($urandom_range(0, 6) == 0) ? $urandom_range(17, 22) :
					$urandom_range(1, 5));
				if ($urandom_range(0, 9) < 4) begin
					add_char(exptok_pkg::CH_POINT);
					add_digits(($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) :
						$urandom_range(0, 4));
					if ($urandom_range(0, 9) == 0)
						add_char(exptok_pkg::CH_POINT);
				end
			end else if (pick < 38) begin
				for (int i = 0; i < near_max.len(); i++)
					add_char(near_max[i]);
				add_digits($urandom_range(1, 2));
				if ($urandom_range(0, 1)) begin
					add_char(exptok_pkg::CH_POINT);
					add_digits($urandom_range(0, 3));
				end
			end else if (pick < 58) begin
				add_name_start();
				n = ($urandom_range(0, 6) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 9) < 2)
						add_char(exptok_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
					else if ($urandom_range(0, 9) == 0)
						add_char(exptok_pkg::CH_UNDER);
					else
						add_char(8'h61 + 8'($urandom_range(0, 25)));
				end
			end else if (pick < 80) begin
				add_operator();
			end else if (pick < 86) begin
				add_space();
			end else if (pick < 94) begin
				add_char(8'($urandom_range(0, 255)));
			end else begin
				add_eos();
			end
			pick = $urandom_range(0, 9);
			if (pick < 4)
				add_space();
			else if (pick == 4)
				add_eos();
		end
		add_eos();
	endtask

	task automatic check_field(input string fname, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : score
		token_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_tokens(cmd, ch);
				if (char_stream[taken].typed) begin
					want = blank_token(char_stream[taken].kind);
					want.last = 1'b1;
					awaited_tokens.push_back(want);
				end else begin
					foreach (batch[i])
						awaited_tokens.push_back(batch[i]);
				end
				taken++;
			end
			if (out_valid && out_ready) begin
				if (awaited_tokens.size() == 0) begin
					$error("token of kind %0d arrived with none outstanding", kind);
					errors++;
				end else begin
					want = awaited_tokens.pop_front();
					check_field("kind", 64'(want.kind), 64'(kind));
					check_field("mantissa", 64'(want.mant), 64'(mantissa));
					check_field("frac_digits", 64'(want.frac), 64'(frac_digits));
					check_field("name_low", want.lo, name_low);
					check_field("name_high", want.hi, name_high);
					check_field("name_len", 64'(want.len), 64'(name_len));
					check_field("clipped", 64'(want.clip), 64'(clipped));
					check_field("last", 64'(want.last), 64'(last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// The receiver switches between always ready, coin-flip and mostly stalled.
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_style = $urandom_range(0, 2);
			ready_left = $urandom_range(8, 80);
		end else begin
			ready_left--;
		end
		case (ready_style)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	initial begin : send_chars
		int idx;
		int burst;
		int gap;
		foreach (directed_rows[i])
			char_stream.push_back(directed_rows[i]);
		build_random_stream();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idx = 0;
		while (idx < char_stream.size()) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			for (int b = 0; b < burst && idx < char_stream.size(); b++) begin
				@(negedge clk);
				in_valid <= 1'b1;
				cmd <= char_stream[idx].cmd;
				ch <= char_stream[idx].ch;
				@(posedge clk);
				while (!in_ready)
					@(posedge clk);
				idx++;
			end
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && awaited_tokens.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[sim.f]
design/exptok_pkg.sv
design/exptok_core.sv
design/exptok_fifo.sv
design/expression_tokenizer.sv
dv/tb_expression_tokenizer.sv
